[src/tflr_pkg.sv]
package tflr_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 20;
    localparam int LINE_LEN_W  = 8;
    localparam int AGE_W       = 20;
    localparam int CHARS_W     = 48;
    localparam int FRAME_LEN   = 7;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [LINE_LEN_W-1:0] MAX_LINE_RESET = 8'd50;
    localparam logic [AGE_W-1:0]      TIMEOUT_RESET  = 20'd30000;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LINE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT  = 8'd1;

    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_Z = 8'h5A;
    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_Z = 8'h7A;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_DATE     = 3'd1,
        EV_TIME     = 3'd2,
        EV_CSUM     = 3'd3,
        EV_FORMAT   = 3'd4,
        EV_OVERFLOW = 3'd5,
        EV_TIMEOUT  = 3'd6
    } event_t;

    typedef struct packed {
        event_t             event_res;
        logic [CHARS_W-1:0] date_chars;
        logic [CHARS_W-1:0] time_chars;
        logic               time_valid;
        logic               data_fresh;
    } result_t;

endpackage

[src/tflr_out_buf.sv]
module tflr_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tflr_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tflr_pkg::result_t out_data
);

    tflr_pkg::result_t main_reg;
    tflr_pkg::result_t skid_reg;
    logic              main_valid_reg;
    logic              skid_valid_reg;
    logic              push;
    logic              pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                main_reg <= in_data;
            end else begin
                main_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg) begin
                main_reg       <= in_data;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

[src/time_frame_line_receiver_top.sv]
// Time frame line receiver. Each request is either a received byte (s_mode 0)
// or a one millisecond tick (s_mode 1), and gives exactly one result: an event
// code plus the stored date and time characters, the valid flag and the
// freshness flag, all as they stand after that request. A request is taken
// every cycle that s_ready is high, and its result is registered in a
// two-entry output buffer that lets two results wait before s_ready drops. The
// digit sum is kept running as bytes arrive, so a line is checked at CR or LF.
// cfg_index 0 writes max_line, 1 writes timeout_ticks; write only when idle.
module time_frame_line_receiver_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tflr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tflr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic [7:0]                         s_rx_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [2:0]                         m_event_res,
    output logic [tflr_pkg::CHARS_W-1:0]       m_date_chars,
    output logic [tflr_pkg::CHARS_W-1:0]       m_time_chars,
    output logic                               m_time_valid,
    output logic                               m_data_fresh
);

    logic [tflr_pkg::LINE_LEN_W-1:0] max_line_reg;
    logic [tflr_pkg::AGE_W-1:0]      timeout_reg;

    logic [tflr_pkg::LINE_LEN_W-1:0] line_len_reg, line_len_next;
    logic [7:0]                      line_head_reg [tflr_pkg::FRAME_LEN];
    logic [3:0]                      sum_reg, sum_next;
    logic [tflr_pkg::CHARS_W-1:0]    date_reg, date_next;
    logic [tflr_pkg::CHARS_W-1:0]    time_reg, time_next;
    logic                            valid_reg, valid_next;
    logic                            date_seen_reg, date_seen_next;
    logic                            time_seen_reg, time_seen_next;
    logic [tflr_pkg::AGE_W-1:0]      age_reg, age_next;

    logic                            accept;
    logic                            head_we;
    logic                            is_digit;
    logic [3:0]                      sum_base;
    logic [4:0]                      sum_add;
    logic [tflr_pkg::LINE_LEN_W:0]   len_inc;
    logic [7:0]                      ck;
    logic [7:0]                      expect_uc;
    logic [7:0]                      expect_lc;
    logic [tflr_pkg::CHARS_W-1:0]    six_chars;
    tflr_pkg::event_t                ev;
    tflr_pkg::result_t               res;
    tflr_pkg::result_t               m_res;
    logic                            buf_ready;

    assign cfg_ready = 1'b1;
    assign s_ready   = buf_ready;
    assign accept    = s_valid && buf_ready;

    assign is_digit  = (s_rx_byte >= tflr_pkg::CHAR_0) && (s_rx_byte <= tflr_pkg::CHAR_9);
    assign sum_base  = (line_len_reg == '0) ? 4'd0 : sum_reg;
    assign sum_add   = {1'b0, sum_base} + (is_digit ? {1'b0, s_rx_byte[3:0]} : 5'd0);
    assign len_inc   = {1'b0, line_len_reg} + 9'd1;
    assign ck        = line_head_reg[6];
    assign expect_uc = tflr_pkg::CHAR_UC_A + {4'd0, sum_reg};
    assign expect_lc = tflr_pkg::CHAR_LC_A + {4'd0, sum_reg};
    assign six_chars = {line_head_reg[0], line_head_reg[1], line_head_reg[2],
                        line_head_reg[3], line_head_reg[4], line_head_reg[5]};

    always_comb begin
        line_len_next  = line_len_reg;
        sum_next       = sum_reg;
        date_next      = date_reg;
        time_next      = time_reg;
        valid_next     = valid_reg;
        date_seen_next = date_seen_reg;
        time_seen_next = time_seen_reg;
        age_next       = age_reg;
        head_we        = 1'b0;
        ev             = tflr_pkg::EV_NONE;
        if (s_mode) begin
            if (age_reg != tflr_pkg::AGE_MAX) begin
                age_next = age_reg + 20'd1;
            end
            if (valid_reg && (age_next > timeout_reg)) begin
                valid_next = 1'b0;
                ev         = tflr_pkg::EV_TIMEOUT;
            end
        end else if ((s_rx_byte == tflr_pkg::CHAR_LF) || (s_rx_byte == tflr_pkg::CHAR_CR)) begin
            if (line_len_reg != '0) begin
                line_len_next = '0;
                if (line_len_reg != 8'(tflr_pkg::FRAME_LEN)) begin
                    ev = tflr_pkg::EV_FORMAT;
                end else if ((ck >= tflr_pkg::CHAR_UC_A) && (ck <= tflr_pkg::CHAR_UC_Z)) begin
                    if (ck != expect_uc) begin
                        ev = tflr_pkg::EV_CSUM;
                    end else begin
                        date_next      = six_chars;
                        date_seen_next = 1'b1;
                        age_next       = '0;
                        ev             = tflr_pkg::EV_DATE;
                    end
                end else if ((ck >= tflr_pkg::CHAR_LC_A) && (ck <= tflr_pkg::CHAR_LC_Z)) begin
                    if (ck != expect_lc) begin
                        ev = tflr_pkg::EV_CSUM;
                    end else begin
                        time_next      = six_chars;
                        time_seen_next = 1'b1;
                        age_next       = '0;
                        valid_next     = 1'b1;
                        ev             = tflr_pkg::EV_TIME;
                    end
                end
            end
        end else begin
            head_we = (line_len_reg < 8'(tflr_pkg::FRAME_LEN));
            if (line_len_reg < 8'(tflr_pkg::FRAME_LEN - 1)) begin
                sum_next = (sum_add >= 5'd10) ? 4'(sum_add - 5'd10) : sum_add[3:0];
            end
            if (len_inc > {1'b0, max_line_reg}) begin
                line_len_next = '0;
                ev            = tflr_pkg::EV_OVERFLOW;
            end else begin
                line_len_next = len_inc[tflr_pkg::LINE_LEN_W-1:0];
            end
        end

        res.event_res  = ev;
        res.date_chars = date_next;
        res.time_chars = time_next;
        res.time_valid = valid_next;
        res.data_fresh = valid_next && (age_next < timeout_reg)
                         && date_seen_next && time_seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_line_reg  <= tflr_pkg::MAX_LINE_RESET;
            timeout_reg   <= tflr_pkg::TIMEOUT_RESET;
            line_len_reg  <= '0;
            sum_reg       <= '0;
            date_reg      <= '0;
            time_reg      <= '0;
            valid_reg     <= 1'b0;
            date_seen_reg <= 1'b0;
            time_seen_reg <= 1'b0;
            age_reg       <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    tflr_pkg::REG_MAX_LINE: max_line_reg <= cfg_data[tflr_pkg::LINE_LEN_W-1:0];
                    tflr_pkg::REG_TIMEOUT:  timeout_reg  <= cfg_data[tflr_pkg::AGE_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                line_len_reg  <= line_len_next;
                sum_reg       <= sum_next;
                date_reg      <= date_next;
                time_reg      <= time_next;
                valid_reg     <= valid_next;
                date_seen_reg <= date_seen_next;
                time_seen_reg <= time_seen_next;
                age_reg       <= age_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && head_we) begin
            line_head_reg[line_len_reg[2:0]] <= s_rx_byte;
        end
    end

    tflr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_res)
    );

    assign m_event_res  = m_res.event_res;
    assign m_date_chars = m_res.date_chars;
    assign m_time_chars = m_res.time_chars;
    assign m_time_valid = m_res.time_valid;
    assign m_data_fresh = m_res.data_fresh;

endmodule
